>>> hdl/mmr_pkg.sv
// Shared types and constants of the mailbox message router.
package mmr_pkg;

  localparam int RESULT_CAP = 64;
  localparam int CAP_W      = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_POST       = 3'd2,
    CMD_SEND       = 3'd3,
    CMD_DISPATCH   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef struct packed {
    logic               status;
    kind_t              kind;
    logic        [2:0]  slot;
    logic        [31:0] from_id;
    logic        [31:0] to_id;
    logic        [15:0] code;
    logic signed [31:0] word_a;
    logic signed [31:0] word_b;
    logic               last;
  } result_t;

endpackage

>>> hdl/mmr_emit.sv
// Output register of the router: holds one result item toward the master side.
module mmr_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mmr_pkg::result_t  res,
  output logic              res_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [151:0]      out_tdata,  // status, slot, from_id, to_id, out_code,
                                        // out_word_a, out_word_b, zero pad
  output logic [1:0]        out_tuser,  // kind
  output logic              out_tlast   // last
);

  logic             valid_r;
  mmr_pkg::result_t res_r;

  assign res_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
      res_r   <= res;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, res_r.word_b, res_r.word_a, res_r.code, res_r.to_id,
                       res_r.from_id, res_r.slot, res_r.status};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

>>> hdl/mailbox_message_router_top.sv
// Top level of the mailbox message router: slot table, mailboxes and sequencer.
//
// Commands arrive on the in_ stream (tuser = command, tdata = id, sender,
// permission, code and two words). Results leave on the out_ stream, tuser
// carrying the kind and tlast marking the final result of a command.
// One command is worked at a time; in_tready is high only while the sequencer
// is idle. Id lookup for register/unregister/post/send steps one slot at a time
// through the owner memory with a single compare unit (read state, then compare
// state) and stops at a hit; id 0, denied or unknown commands skip the lookup.
// Dispatch walks the slots in order (ST_D_CHK per slot, ST_D_META per bound
// slot, ST_D_RD and ST_D_MSG per delivered message through the single read
// port of the message memory); at most 64 messages per dispatch.
// Results go through an output register, so the next command is taken while
// the last result still waits; a stalled receiver holds the sequencer only
// when a further result must be emitted.
// Reset (synchronous, active low) frees all slots and restores the spare
// slot stack; mailbox storage is not cleared, it is reinitialized whenever a
// slot is bound.
module mailbox_message_router_top #(
  parameter int SLOT_COUNT = 8,
  parameter int BOX_DEPTH  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,  // proc_id, sender_id, permitted, msg_code,
                                  // word_a, word_b, zero pad
  input  logic [2:0]   in_tuser,  // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata, // status, slot, from_id, to_id, out_code,
                                  // out_word_a, out_word_b, zero pad
  output logic [1:0]   out_tuser, // kind
  output logic         out_tlast  // last
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int TW = $clog2(SLOT_COUNT + 1);
  localparam int PW = $clog2(BOX_DEPTH);
  localparam int FW = $clog2(BOX_DEPTH + 1);
  localparam int BOX_ENTRIES = SLOT_COUNT * BOX_DEPTH;
  localparam int AW = $clog2(BOX_ENTRIES);
  localparam int CW = mmr_pkg::CAP_W;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [FW-1:0] fill;
  } meta_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_META_RD, ST_EXEC, ST_POP_RD, ST_POP,
    ST_D_CHK, ST_D_META, ST_D_RD, ST_D_MSG, ST_FLUSH
  } state_t;

  state_t              state_r;
  mmr_pkg::cmd_t       cmd_r;
  logic [31:0]         id_r;
  logic [31:0]         sender_r;
  logic [15:0]         code_r;
  logic signed [31:0]  wa_r;
  logic signed [31:0]  wb_r;
  logic [SW-1:0]       scan_idx_r;
  logic [SW-1:0]       slot_r;
  logic [SW-1:0]       d_slot_r;
  logic [SLOT_COUNT-1:0] valid_r;
  logic [TW-1:0]       top_r;
  logic [TW-1:0]       low_r;
  logic [CW-1:0]       n_r;
  logic [PW-1:0]       cur_head_r;
  logic [PW-1:0]       cur_tail_r;
  logic [FW-1:0]       cur_fill_r;
  mmr_pkg::result_t    hold_r;
  logic                hold_v_r;

  logic [31:0]  owner_ram_r [SLOT_COUNT];
  meta_t        meta_ram_r  [SLOT_COUNT];
  logic [SW-1:0] stack_ram_r [SLOT_COUNT];
  logic [111:0] box_ram_r   [BOX_ENTRIES];
  logic [31:0]  owner_q_r;
  meta_t        meta_q_r;
  logic [SW-1:0] stack_q_r;
  logic [111:0] box_q_r;

  logic             res_ready;
  logic             push;
  mmr_pkg::result_t push_res;
  mmr_pkg::result_t deliv_d;
  mmr_pkg::result_t send_d;
  logic [TW-1:0]    pop_idx;
  logic [SW-1:0]    pop_slot;
  logic             hit;
  logic             last_scan;
  logic             d_last;
  logic             full;
  logic             n_room;
  logic             msg_go;
  logic             post_ok;
  logic             meta_we;
  logic [SW-1:0]    meta_wa;
  meta_t            meta_wd;
  logic [AW-1:0]    box_wa;
  logic [AW-1:0]    box_ra;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(BOX_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic mmr_pkg::result_t ack(input logic fail, input logic [2:0] s);
    mmr_pkg::result_t r;
    r        = '0;
    r.status = fail;
    r.kind   = mmr_pkg::KIND_ACK;
    r.slot   = fail ? 3'd0 : s;
    ack      = r;
  endfunction

  assign in_tready = (state_r == ST_IDLE);

  assign pop_idx   = TW'(top_r - 1'b1);
  assign pop_slot  = (pop_idx < low_r) ? SW'(SW'(SLOT_COUNT - 1) - pop_idx[SW-1:0])
                                       : stack_q_r;
  assign hit       = valid_r[scan_idx_r] && (owner_q_r == id_r);
  assign last_scan = (scan_idx_r == SW'(SLOT_COUNT - 1));
  assign d_last    = (d_slot_r == SW'(SLOT_COUNT - 1));
  assign full      = (meta_q_r.fill >= FW'(BOX_DEPTH));
  assign n_room    = (n_r < CW'(mmr_pkg::RESULT_CAP));
  assign msg_go    = (state_r == ST_D_MSG) && (!hold_v_r || res_ready);
  assign post_ok   = (state_r == ST_EXEC) && (cmd_r == mmr_pkg::CMD_POST) && !full;
  assign box_wa    = AW'(AW'(slot_r) * AW'(BOX_DEPTH)) + AW'(meta_q_r.tail);
  assign box_ra    = AW'(AW'(d_slot_r) * AW'(BOX_DEPTH)) + AW'(cur_head_r);

  always_comb begin
    deliv_d         = '0;
    deliv_d.kind    = mmr_pkg::KIND_DELIVER;
    deliv_d.slot    = 3'(d_slot_r);
    deliv_d.from_id = box_q_r[31:0];
    deliv_d.to_id   = owner_q_r;
    deliv_d.code    = box_q_r[47:32];
    deliv_d.word_a  = box_q_r[79:48];
    deliv_d.word_b  = box_q_r[111:80];
  end

  always_comb begin
    send_d         = '0;
    send_d.kind    = mmr_pkg::KIND_DELIVER;
    send_d.slot    = 3'(slot_r);
    send_d.from_id = sender_r;
    send_d.to_id   = id_r;
    send_d.code    = code_r;
    send_d.word_a  = wa_r;
    send_d.word_b  = wb_r;
  end

  always_comb begin
    push     = 1'b0;
    push_res = hold_r;
    if (state_r == ST_FLUSH) begin
      push = res_ready;
      if (hold_v_r) begin
        push_res.last = 1'b1;
      end else begin
        push_res      = '0;
        push_res.kind = mmr_pkg::KIND_EMPTY;
        push_res.last = 1'b1;
      end
    end else if (msg_go && hold_v_r) begin
      push = 1'b1;
    end
  end

  always_comb begin
    meta_we = 1'b0;
    meta_wa = slot_r;
    meta_wd = '0;
    case (state_r)
      ST_POP: begin
        meta_we = 1'b1;
        meta_wa = pop_slot;
      end
      ST_EXEC: begin
        if (cmd_r == mmr_pkg::CMD_REGISTER) begin
          meta_we = 1'b1;
        end else if (post_ok) begin
          meta_we      = 1'b1;
          meta_wd.head = meta_q_r.head;
          meta_wd.tail = wrap_inc(meta_q_r.tail);
          meta_wd.fill = FW'(meta_q_r.fill + 1'b1);
        end
      end
      ST_D_MSG: begin
        meta_we      = msg_go;
        meta_wa      = d_slot_r;
        meta_wd.head = wrap_inc(cur_head_r);
        meta_wd.tail = cur_tail_r;
        meta_wd.fill = FW'(cur_fill_r - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_POP) begin
      owner_ram_r[pop_slot] <= id_r;
    end
    if (state_r == ST_SCAN_RD) begin
      owner_q_r <= owner_ram_r[scan_idx_r];
    end else if (state_r == ST_D_CHK) begin
      owner_q_r <= owner_ram_r[d_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_ram_r[meta_wa] <= meta_wd;
    end
    if (state_r == ST_META_RD) begin
      meta_q_r <= meta_ram_r[slot_r];
    end else if (state_r == ST_D_CHK) begin
      meta_q_r <= meta_ram_r[d_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC && cmd_r == mmr_pkg::CMD_UNREGISTER &&
        top_r < TW'(SLOT_COUNT)) begin
      stack_ram_r[top_r[SW-1:0]] <= slot_r;
    end
    if (state_r == ST_POP_RD) begin
      stack_q_r <= stack_ram_r[pop_idx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (post_ok) begin
      box_ram_r[box_wa] <= {wb_r, wa_r, code_r, sender_r};
    end
    if (state_r == ST_D_RD) begin
      box_q_r <= box_ram_r[box_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      top_r    <= TW'(SLOT_COUNT);
      low_r    <= TW'(SLOT_COUNT);
      hold_v_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r      <= mmr_pkg::cmd_t'(in_tuser);
            id_r       <= in_tdata[31:0];
            sender_r   <= in_tdata[63:32];
            code_r     <= in_tdata[80:65];
            wa_r       <= in_tdata[112:81];
            wb_r       <= in_tdata[144:113];
            scan_idx_r <= '0;
            d_slot_r   <= '0;
            n_r        <= '0;
            hold_r     <= ack(1'b1, 3'd0);
            hold_v_r   <= 1'b1;
            state_r    <= ST_FLUSH;
            case (mmr_pkg::cmd_t'(in_tuser))
              mmr_pkg::CMD_DISPATCH: begin
                hold_v_r <= 1'b0;
                state_r  <= ST_D_CHK;
              end
              mmr_pkg::CMD_REGISTER, mmr_pkg::CMD_UNREGISTER: begin
                if (in_tdata[31:0] != 32'd0) begin
                  state_r <= ST_SCAN_RD;
                end
              end
              mmr_pkg::CMD_POST, mmr_pkg::CMD_SEND: begin
                if (in_tdata[31:0] != 32'd0 && in_tdata[64]) begin
                  state_r <= ST_SCAN_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN_RD: begin
          state_r <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          if (hit) begin
            slot_r  <= scan_idx_r;
            state_r <= ST_META_RD;
          end else if (last_scan) begin
            if (cmd_r == mmr_pkg::CMD_REGISTER && top_r != '0) begin
              state_r <= ST_POP_RD;
            end else begin
              state_r <= ST_FLUSH;
            end
          end else begin
            scan_idx_r <= SW'(scan_idx_r + 1'b1);
            state_r    <= ST_SCAN_RD;
          end
        end
        ST_META_RD: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          state_r <= ST_FLUSH;
          case (cmd_r)
            mmr_pkg::CMD_REGISTER: begin
              hold_r <= ack(1'b0, 3'(slot_r));
            end
            mmr_pkg::CMD_UNREGISTER: begin
              valid_r[slot_r] <= 1'b0;
              if (top_r < TW'(SLOT_COUNT)) begin
                top_r <= TW'(top_r + 1'b1);
              end
              hold_r <= ack(1'b0, 3'(slot_r));
            end
            mmr_pkg::CMD_SEND: begin
              hold_r <= send_d;
            end
            mmr_pkg::CMD_POST: begin
              hold_r <= ack(full, 3'(slot_r));
            end
            default: ;
          endcase
        end
        ST_POP_RD: begin
          state_r <= ST_POP;
        end
        ST_POP: begin
          valid_r[pop_slot] <= 1'b1;
          top_r             <= pop_idx;
          if (pop_idx < low_r) begin
            low_r <= pop_idx;
          end
          hold_r  <= ack(1'b0, 3'(pop_slot));
          state_r <= ST_FLUSH;
        end
        ST_D_CHK: begin
          if (valid_r[d_slot_r]) begin
            state_r <= ST_D_META;
          end else if (d_last) begin
            state_r <= ST_FLUSH;
          end else begin
            d_slot_r <= SW'(d_slot_r + 1'b1);
          end
        end
        ST_D_META: begin
          cur_head_r <= meta_q_r.head;
          cur_tail_r <= meta_q_r.tail;
          cur_fill_r <= meta_q_r.fill;
          if (meta_q_r.fill != '0 && n_room) begin
            state_r <= ST_D_RD;
          end else if (d_last || !n_room) begin
            state_r <= ST_FLUSH;
          end else begin
            d_slot_r <= SW'(d_slot_r + 1'b1);
            state_r  <= ST_D_CHK;
          end
        end
        ST_D_RD: begin
          state_r <= ST_D_MSG;
        end
        ST_D_MSG: begin
          if (msg_go) begin
            hold_r     <= deliv_d;
            hold_v_r   <= 1'b1;
            n_r        <= CW'(n_r + 1'b1);
            cur_head_r <= wrap_inc(cur_head_r);
            cur_fill_r <= FW'(cur_fill_r - 1'b1);
            if (cur_fill_r > FW'(1) && n_r < CW'(mmr_pkg::RESULT_CAP - 1)) begin
              state_r <= ST_D_RD;
            end else if (d_last || n_r == CW'(mmr_pkg::RESULT_CAP - 1)) begin
              state_r <= ST_FLUSH;
            end else begin
              d_slot_r <= SW'(d_slot_r + 1'b1);
              state_r  <= ST_D_CHK;
            end
          end
        end
        ST_FLUSH: begin
          if (res_ready) begin
            hold_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  mmr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res        (push_res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sim/tb_mailbox_message_router_top.sv
// Self-checking testbench of the mailbox message router: directed and random commands.
`timescale 1ns / 1ps

module tb_mailbox_message_router_top;

  localparam int SLOTS     = 8;
  localparam int DEPTH     = 8;
  localparam int N_RANDOM  = 400;
  localparam int WD_LIMIT  = 6000;
  localparam int CALM_TAIL = 60;

  typedef struct {
    logic [2:0]         cmd;
    logic [31:0]        proc_id;
    logic [31:0]        sender_id;
    logic               permitted;
    logic [15:0]        code;
    logic signed [31:0] word_a;
    logic signed [31:0] word_b;
    bit                 drain;
  } cmd_item_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  mailbox_message_router_top #(.SLOT_COUNT(SLOTS), .BOX_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // router image
  bit                 slot_used [SLOTS];
  logic [31:0]        slot_id   [SLOTS];
  int                 spare     [SLOTS];
  int                 spare_cnt;
  int                 box_rd [SLOTS], box_wr [SLOTS], box_cnt [SLOTS];
  logic [31:0]        msg_from [SLOTS][DEPTH];
  logic [15:0]        msg_code [SLOTS][DEPTH];
  logic signed [31:0] msg_wa   [SLOTS][DEPTH];
  logic signed [31:0] msg_wb   [SLOTS][DEPTH];

  cmd_item_t          pending_cmds[$];
  mmr_pkg::result_t   due_results[$];
  logic [31:0]        id_pool[$];
  int          errors, cmds_done, results_seen, deliveries_seen, total_cmds;
  int          in_gap, out_gap, idle_cycles;
  bit          calm;

  function automatic int find_slot(logic [31:0] id);
    if (id == 0) return -1;
    for (int s = 0; s < SLOTS; s++)
      if (slot_used[s] && slot_id[s] == id) return s;
    return -1;
  endfunction

  task automatic push_ack(logic st, int s);
    mmr_pkg::result_t r;
    r = '0;
    r.status = st;
    r.kind = mmr_pkg::KIND_ACK;
    r.slot = st ? 3'd0 : 3'(s);
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  task automatic route_command(cmd_item_t c);
    mmr_pkg::result_t r;
    int s, n;
    r = '0;
    s = -1;
    n = 0;
    case (c.cmd)
      mmr_pkg::CMD_REGISTER: begin
        s = find_slot(c.proc_id);
        if (c.proc_id == 0) begin
          push_ack(1'b1, 0);
        end else if (s >= 0) begin
          box_rd[s] = 0; box_wr[s] = 0; box_cnt[s] = 0;
          push_ack(1'b0, s);
        end else if (spare_cnt == 0) begin
          push_ack(1'b1, 0);
        end else begin
          spare_cnt--;
          s = spare[spare_cnt];
          slot_used[s] = 1'b1;
          slot_id[s] = c.proc_id;
          box_rd[s] = 0; box_wr[s] = 0; box_cnt[s] = 0;
          push_ack(1'b0, s);
        end
      end
      mmr_pkg::CMD_UNREGISTER: begin
        s = find_slot(c.proc_id);
        if (s < 0) begin
          push_ack(1'b1, 0);
        end else begin
          slot_used[s] = 1'b0;
          slot_id[s] = '0;
          box_rd[s] = 0; box_wr[s] = 0; box_cnt[s] = 0;
          if (spare_cnt < SLOTS) begin
            spare[spare_cnt] = s;
            spare_cnt++;
          end
          push_ack(1'b0, s);
        end
      end
      mmr_pkg::CMD_POST, mmr_pkg::CMD_SEND: begin
        if (c.permitted) s = find_slot(c.proc_id);
        if (s < 0) begin
          push_ack(1'b1, 0);
        end else if (c.cmd == mmr_pkg::CMD_SEND) begin
          r.kind = mmr_pkg::KIND_DELIVER;
          r.slot = 3'(s);
          r.from_id = c.sender_id;
          r.to_id = c.proc_id;
          r.code = c.code;
          r.word_a = c.word_a;
          r.word_b = c.word_b;
          r.last = 1'b1;
          due_results.push_back(r);
        end else if (box_cnt[s] >= DEPTH) begin
          push_ack(1'b1, 0);
        end else begin
          msg_from[s][box_wr[s]] = c.sender_id;
          msg_code[s][box_wr[s]] = c.code;
          msg_wa[s][box_wr[s]] = c.word_a;
          msg_wb[s][box_wr[s]] = c.word_b;
          box_wr[s] = (box_wr[s] + 1) % DEPTH;
          box_cnt[s]++;
          push_ack(1'b0, s);
        end
      end
      mmr_pkg::CMD_DISPATCH: begin
        for (int k = 0; k < SLOTS; k++) begin
          while (slot_used[k] && box_cnt[k] > 0 && n < mmr_pkg::RESULT_CAP) begin
            r = '0;
            r.kind = mmr_pkg::KIND_DELIVER;
            r.slot = 3'(k);
            r.from_id = msg_from[k][box_rd[k]];
            r.to_id = slot_id[k];
            r.code = msg_code[k][box_rd[k]];
            r.word_a = msg_wa[k][box_rd[k]];
            r.word_b = msg_wb[k][box_rd[k]];
            due_results.push_back(r);
            box_rd[k] = (box_rd[k] + 1) % DEPTH;
            box_cnt[k]--;
            n++;
          end
        end
        if (n == 0) begin
          r = '0;
          r.kind = mmr_pkg::KIND_EMPTY;
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          due_results[$].last = 1'b1;
        end
      end
      default: push_ack(1'b1, 0);
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got,
             want);
  endtask

  task automatic add_cmd(logic [2:0] cmd, logic [31:0] id, logic perm = 1'b1,
                         bit drain = 1'b0);
    cmd_item_t c;
    c.cmd = cmd;
    c.proc_id = id;
    c.sender_id = $urandom;
    c.permitted = perm;
    c.code = 16'($urandom);
    c.word_a = $urandom;
    c.word_b = $urandom;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [31:0] pick_id();
    return id_pool[$urandom_range(0, id_pool.size() - 1)];
  endfunction

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cmds_done++;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 16);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && due_results.size() > 0)) begin
          cmd_item_t c;
          c = pending_cmds.pop_front();
          route_command(c);
          in_tuser <= c.cmd;
          in_tdata <= {7'd0, c.word_b, c.word_a, c.code, c.permitted, c.sender_id,
                       c.proc_id};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    mmr_pkg::result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report("unexpected result", out_tdata[31:0], '0);
        end else begin
          want = due_results.pop_front();
          if (want.kind == mmr_pkg::KIND_DELIVER) deliveries_seen++;
          if (out_tdata[0] !== want.status) report("status", out_tdata[0], want.status);
          if (out_tuser !== want.kind) report("kind", out_tuser, want.kind);
          if (out_tdata[3:1] !== want.slot) report("slot", out_tdata[3:1], want.slot);
          if (out_tdata[35:4] !== want.from_id) report("from_id", out_tdata[35:4],
                                                       want.from_id);
          if (out_tdata[67:36] !== want.to_id) report("to_id", out_tdata[67:36],
                                                      want.to_id);
          if (out_tdata[83:68] !== want.code) report("code", out_tdata[83:68], want.code);
          if (out_tdata[115:84] !== want.word_a) report("word_a", out_tdata[115:84],
                                                        want.word_a);
          if (out_tdata[147:116] !== want.word_b) report("word_b", out_tdata[147:116],
                                                         want.word_b);
          if (out_tlast !== want.last) report("last", out_tlast, want.last);
        end
      end
      calm = (cmds_done >= total_cmds - CALM_TAIL);
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WD_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int p;
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_id[s] = '0;
      spare[s] = SLOTS - 1 - s;
      box_rd[s] = 0; box_wr[s] = 0; box_cnt[s] = 0;
    end
    spare_cnt = SLOTS;
    id_pool = '{32'hFFFF_FFFF, 32'd1, 32'h8000_0000};
    for (int k = 0; k < 9; k++) id_pool.push_back($urandom | 32'd1);

    // directed
    add_cmd(mmr_pkg::CMD_REGISTER, 32'd0);
    add_cmd(mmr_pkg::CMD_DISPATCH, 32'd0);
    for (int k = 0; k < SLOTS; k++) add_cmd(mmr_pkg::CMD_REGISTER, id_pool[k]);
    add_cmd(mmr_pkg::CMD_REGISTER, id_pool[SLOTS]);
    for (int k = 0; k < DEPTH + 1; k++) add_cmd(mmr_pkg::CMD_POST, id_pool[0]);
    add_cmd(mmr_pkg::CMD_POST, id_pool[1], 1'b0);
    add_cmd(mmr_pkg::CMD_POST, 32'd0);
    add_cmd(mmr_pkg::CMD_SEND, id_pool[2]);
    add_cmd(mmr_pkg::CMD_SEND, id_pool[2], 1'b0);
    add_cmd(mmr_pkg::CMD_SEND, id_pool[SLOTS]);
    add_cmd(mmr_pkg::CMD_POST, id_pool[1]);
    add_cmd(mmr_pkg::CMD_REGISTER, id_pool[1]);
    add_cmd(mmr_pkg::CMD_DISPATCH, 32'd0);
    add_cmd(mmr_pkg::CMD_UNREGISTER, id_pool[SLOTS]);
    add_cmd(mmr_pkg::CMD_UNREGISTER, id_pool[3]);
    add_cmd(3'd5, id_pool[0]);
    add_cmd(3'd7, id_pool[0]);

    // random: mostly traffic among known ids
    for (int k = 0; k < N_RANDOM; k++) begin
      p = $urandom_range(0, 99);
      if (k == N_RANDOM / 2) add_cmd(mmr_pkg::CMD_DISPATCH, 32'd0, 1'b1, 1'b1);
      else if (p < 14) add_cmd(mmr_pkg::CMD_REGISTER, pick_id());
      else if (p < 22) add_cmd(mmr_pkg::CMD_UNREGISTER, pick_id());
      else if (p < 60) add_cmd(mmr_pkg::CMD_POST, pick_id(), $urandom_range(0, 9) != 0);
      else if (p < 74) add_cmd(mmr_pkg::CMD_SEND, pick_id(), $urandom_range(0, 9) != 0);
      else if (p < 86) add_cmd(mmr_pkg::CMD_DISPATCH, $urandom);
      else if (p < 89) add_cmd(3'($urandom_range(5, 7)), pick_id());
      else if (p < 92) add_cmd(3'($urandom_range(0, 3)), 32'd0);
      else add_cmd(3'($urandom_range(0, 3)), $urandom);
    end
    add_cmd(mmr_pkg::CMD_DISPATCH, 32'd0);
    total_cmds = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_tvalid);
    wait (due_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d message deliveries", cmds_done,
             results_seen, deliveries_seen);
    $display("with random stalls on both streams, a full slot table and full mailboxes");
    if (errors == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
